>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication or expression on every rising clock edge outside reset.
`define RPG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define RPG_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/rpg_pkg.sv
`default_nettype none

package rpg_pkg;

  localparam int unsigned CountW      = 7;
  localparam int unsigned SeedW       = 31;
  localparam int unsigned PosW        = 6;
  localparam int unsigned ValW        = 6;
  localparam int unsigned MaxCountDef = 64;

  // Lehmer generator: x <= A * x mod M, M = 2^31 - 1
  localparam int unsigned LehmerA  = 16807;
  localparam int unsigned LehmerAW = 15;
  localparam logic [SeedW-1:0] LehmerM = 31'h7fff_ffff;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_GEN_MUL,
    ST_GEN_FOLD,
    ST_J_MUL,
    ST_J_FOLD,
    ST_SW_RD,
    ST_SW_W1,
    ST_SW_W2,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic fill_we;
    logic i_clr;
    logic i_inc;
    logic gen_mul;
    logic gen_fold;
    logic j_mul;
    logic j_fold;
    logic sw_w1;
    logic sw_w2;
  } cmd_t;

  typedef struct packed {
    logic in_zero;
    logic last_idx;
    logic n_one;
    logic shuf_done;
  } status_t;

endpackage

`default_nettype wire

>>> rtl/random_permutation_generator_unit.sv
`default_nettype none

// Random permutation generator. Each input word carries a count n (saturated to
// MaxCount; zero gives no output but still applies a reseed) and, when tuser is
// set, a new seed for the minimal-standard Lehmer generator; the seed persists
// between requests. The unit fills its store with 0..n-1, runs a Fisher-Yates
// shuffle and streams n words (position, value) with tlast on the final one.
// Input is taken only while idle. A request runs the fill, the shuffle and the
// output in sequence, and output stalls lengthen it: the fill and the swaps share the
// single write port of the store, each shuffle step runs the generator
// multiply and fold, the index multiply and fold, one read and two writes in
// sequence, and each output word needs a registered store read.
module random_permutation_generator_unit #(
  parameter int unsigned MaxCount = rpg_pkg::MaxCountDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [39:0] s_axis_tdata_i,   // count[6:0], new_seed[37:7], zero fill
  input  wire logic        s_axis_tuser_i,   // reseed
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [15:0] m_axis_tdata_o,   // position[5:0], value[11:6], zero fill
  output logic             m_axis_tlast_o    // last
);

  rpg_pkg::cmd_t    cmd;
  rpg_pkg::status_t status;

  logic [rpg_pkg::PosW-1:0] position;
  logic [rpg_pkg::ValW-1:0] value;

  rpg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rpg_datapath #(
    .MaxCount (MaxCount)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .count_i    (s_axis_tdata_i[6:0]),
    .reseed_i   (s_axis_tuser_i),
    .new_seed_i (s_axis_tdata_i[37:7]),
    .cmd_i      (cmd),
    .status_o   (status),
    .position_o (position),
    .value_o    (value),
    .last_o     (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {4'b0000, value, position};

endmodule

`default_nettype wire

>>> rtl/rpg_ram.sv
`default_nettype none

module rpg_ram #(
  parameter int unsigned Width = 6,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_a_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic      [Width-1:0]         rdata_a_o,
  output logic      [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

>>> rtl/rpg_datapath.sv
`default_nettype none
`include "assert_macros.svh"

module rpg_datapath #(
  parameter int unsigned MaxCount = rpg_pkg::MaxCountDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [rpg_pkg::CountW-1:0]    count_i,
  input  wire logic                          reseed_i,
  input  wire logic [rpg_pkg::SeedW-1:0]     new_seed_i,
  input  wire rpg_pkg::cmd_t                 cmd_i,
  output rpg_pkg::status_t                   status_o,
  output logic      [rpg_pkg::PosW-1:0]      position_o,
  output logic      [rpg_pkg::ValW-1:0]      value_o,
  output logic                               last_o
);

  localparam int unsigned IdxW   = $clog2(MaxCount);
  localparam int unsigned CntW   = rpg_pkg::CountW;
  localparam int unsigned SeedW  = rpg_pkg::SeedW;
  localparam int unsigned ProdW  = SeedW + rpg_pkg::LehmerAW;
  localparam int unsigned JProdW = SeedW + CntW;

  logic [CntW-1:0]   n_q, n_d;
  logic [IdxW-1:0]   i_q, i_d;
  logic [SeedW-1:0]  seed_q, seed_d;
  logic [ProdW-1:0]  prod_q, prod_d;
  logic [JProdW-1:0] jp_q, jp_d;
  logic [IdxW-1:0]   k_q, k_d;
  logic [IdxW-1:0]   hold_q, hold_d;

  logic [CntW-1:0]   i_ext;
  logic [CntW-1:0]   span;
  logic [SeedW-1:0]  seed_load;
  logic [SeedW-1:0]  seed_next;
  logic [SeedW:0]    seed_sum;
  logic [CntW-1:0]   q0;
  logic [CntW-1:0]   quot;
  logic [SeedW:0]    jrem;

  logic              we;
  logic [IdxW-1:0]   waddr;
  logic [IdxW-1:0]   wdata;
  logic [IdxW-1:0]   rdata_a;
  logic [IdxW-1:0]   rdata_b;

  assign i_ext = CntW'(i_q);
  assign span  = n_q - i_ext;

  // Map the two degenerate seeds to one.
  assign seed_load = (new_seed_i == '0 || new_seed_i == rpg_pkg::LehmerM) ?
                     SeedW'(1) : new_seed_i;

  // Mersenne fold of the product: p mod (2^31-1) = lo + hi, one correction.
  always_comb begin
    seed_sum  = (SeedW+1)'(prod_q[SeedW-1:0]) + (SeedW+1)'(prod_q[ProdW-1:SeedW]);
    seed_next = (seed_sum >= (SeedW+1)'(rpg_pkg::LehmerM)) ?
                SeedW'(seed_sum - (SeedW+1)'(rpg_pkg::LehmerM)) : SeedW'(seed_sum);
  end

  // floor(t / M): t = q0*M + (q0 + lo), remainder below 2M.
  always_comb begin
    q0   = jp_q[JProdW-1:SeedW];
    jrem = (SeedW+1)'(jp_q[SeedW-1:0]) + (SeedW+1)'(q0);
    quot = q0 + ((jrem >= (SeedW+1)'(rpg_pkg::LehmerM)) ? CntW'(1) : CntW'(0));
  end

  always_comb begin
    n_d    = n_q;
    i_d    = i_q;
    seed_d = seed_q;
    prod_d = prod_q;
    jp_d   = jp_q;
    k_d    = k_q;
    hold_d = hold_q;
    if (cmd_i.load) begin
      n_d = (count_i > CntW'(MaxCount)) ? CntW'(MaxCount) : count_i;
      i_d = '0;
      if (reseed_i) begin
        seed_d = seed_load;
      end
    end else if (cmd_i.i_clr) begin
      i_d = '0;
    end else if (cmd_i.i_inc) begin
      i_d = i_q + IdxW'(1);
    end
    if (cmd_i.gen_mul) begin
      prod_d = ProdW'(seed_q) * ProdW'(rpg_pkg::LehmerA);
    end
    if (cmd_i.gen_fold) begin
      seed_d = seed_next;
    end
    if (cmd_i.j_mul) begin
      jp_d = JProdW'(seed_q) * JProdW'(span);
    end
    if (cmd_i.j_fold) begin
      k_d = IdxW'(i_ext + quot);
    end
    if (cmd_i.sw_w1) begin
      hold_d = rdata_a;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q    <= '0;
      i_q    <= '0;
      seed_q <= SeedW'(1);
      k_q    <= '0;
    end else begin
      n_q    <= n_d;
      i_q    <= i_d;
      seed_q <= seed_d;
      k_q    <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    jp_q   <= jp_d;
    hold_q <= hold_d;
  end

  // Swap: first write entry i with entry k, then entry k with the held entry i.
  assign we    = cmd_i.fill_we | cmd_i.sw_w1 | cmd_i.sw_w2;
  assign waddr = cmd_i.sw_w2 ? k_q : i_q;
  assign wdata = cmd_i.fill_we ? i_q : (cmd_i.sw_w1 ? rdata_b : hold_q);

  rpg_ram #(
    .Width (IdxW),
    .Depth (MaxCount)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (i_q),
    .raddr_b_i (k_q),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  assign status_o.in_zero   = (count_i == '0);
  assign status_o.last_idx  = (i_ext == n_q - CntW'(1));
  assign status_o.n_one     = (n_q == CntW'(1));
  assign status_o.shuf_done = (i_ext + CntW'(2) == n_q);

  assign position_o = rpg_pkg::PosW'(i_q);
  assign value_o    = rpg_pkg::ValW'(rdata_a);
  assign last_o     = status_o.last_idx;

  `RPG_ASSERT_NEVER(a_seed_legal, clk_i, rst_ni,
                    seed_q == '0 || seed_q == rpg_pkg::LehmerM, "seed left the generator range")
  `RPG_ASSERT(a_waddr_in_range, clk_i, rst_ni, we |-> (CntW'(waddr) < n_q),
              "store write beyond current count")

endmodule

`default_nettype wire

>>> rtl/rpg_ctrl.sv
`default_nettype none
`include "assert_macros.svh"

module rpg_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire rpg_pkg::status_t status_i,
  output rpg_pkg::cmd_t         cmd_o
);

  rpg_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rpg_pkg::ST_IDLE: begin
        if (in_valid_i && !status_i.in_zero) begin
          state_d = rpg_pkg::ST_FILL;
        end
      end
      rpg_pkg::ST_FILL: begin
        if (status_i.last_idx) begin
          state_d = status_i.n_one ? rpg_pkg::ST_EMIT_RD : rpg_pkg::ST_GEN_MUL;
        end
      end
      rpg_pkg::ST_GEN_MUL:  state_d = rpg_pkg::ST_GEN_FOLD;
      rpg_pkg::ST_GEN_FOLD: state_d = rpg_pkg::ST_J_MUL;
      rpg_pkg::ST_J_MUL:    state_d = rpg_pkg::ST_J_FOLD;
      rpg_pkg::ST_J_FOLD:   state_d = rpg_pkg::ST_SW_RD;
      rpg_pkg::ST_SW_RD:    state_d = rpg_pkg::ST_SW_W1;
      rpg_pkg::ST_SW_W1:    state_d = rpg_pkg::ST_SW_W2;
      rpg_pkg::ST_SW_W2: begin
        state_d = status_i.shuf_done ? rpg_pkg::ST_EMIT_RD : rpg_pkg::ST_GEN_MUL;
      end
      rpg_pkg::ST_EMIT_RD:  state_d = rpg_pkg::ST_EMIT_OUT;
      rpg_pkg::ST_EMIT_OUT: begin
        if (out_ready_i) begin
          state_d = status_i.last_idx ? rpg_pkg::ST_IDLE : rpg_pkg::ST_EMIT_RD;
        end
      end
      default: state_d = rpg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      rpg_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      rpg_pkg::ST_FILL: begin
        cmd_o.fill_we = 1'b1;
        cmd_o.i_clr   = status_i.last_idx;
        cmd_o.i_inc   = !status_i.last_idx;
      end
      rpg_pkg::ST_GEN_MUL:  cmd_o.gen_mul  = 1'b1;
      rpg_pkg::ST_GEN_FOLD: cmd_o.gen_fold = 1'b1;
      rpg_pkg::ST_J_MUL:    cmd_o.j_mul    = 1'b1;
      rpg_pkg::ST_J_FOLD:   cmd_o.j_fold   = 1'b1;
      rpg_pkg::ST_SW_RD: begin
      end
      rpg_pkg::ST_SW_W1:    cmd_o.sw_w1    = 1'b1;
      rpg_pkg::ST_SW_W2: begin
        cmd_o.sw_w2 = 1'b1;
        cmd_o.i_clr = status_i.shuf_done;
        cmd_o.i_inc = !status_i.shuf_done;
      end
      rpg_pkg::ST_EMIT_RD: begin
      end
      rpg_pkg::ST_EMIT_OUT: begin
        out_valid_o = 1'b1;
        cmd_o.i_inc = out_ready_i && !status_i.last_idx;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rpg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `RPG_ASSERT(a_start_fill, clk_i, rst_ni,
              (in_valid_i && in_ready_o && !status_i.in_zero) |=> (state_q == rpg_pkg::ST_FILL),
              "request with nonzero count did not start the fill")
  `RPG_ASSERT(a_next_word, clk_i, rst_ni,
              (out_valid_o && out_ready_i && !status_i.last_idx) |=>
              (state_q == rpg_pkg::ST_EMIT_RD), "output run ended early")

endmodule

`default_nettype wire
